// ===== rtl/sitda_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII converter.
// Used by sitda_ctrl, sitda_dp and the top level signed_int_to_decimal_ascii.
// Depends on nothing.
package sitda_pkg;

  // Default integer width of the input value.
  localparam int unsigned DefWidth = 32;

  // ASCII codes of the emitted characters.
  localparam logic [6:0] CharZero  = 7'd48;
  localparam logic [6:0] CharMinus = 7'd45;
  localparam logic [6:0] CharNine  = 7'd57;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // Capture a new value and start conversion.
    logic conv;   // One shift-add-3 conversion step.
    logic skip;   // Drop one leading zero digit.
    logic emit;   // Send one character to the output register.
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_last;  // The current conversion step is the final one.
    logic top_zero;   // The most significant remaining digit is zero.
    logic dig_last;   // Only one digit remains.
    logic sign_pend;  // A minus sign still has to go out.
    logic out_free;   // The output register can take a character this cycle.
  } dp_sts_t;

endpackage

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII converter, one character per output transaction,
// most significant first, with a leading '-' for negative values and tlast on the
// final digit. Each value is loaded, converted in WIDTH bit-serial shift-add-3 steps in
// the BCD register, stripped of its leading zeros, which number digit slots minus
// digits (ten slots at WIDTH 32), and then sent out one character at a time. A new
// value is accepted only once the last character has entered the output register.
// Depends on sitda_pkg, sitda_ctrl and sitda_dp.
module signed_int_to_decimal_ascii import sitda_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [((WIDTH + 7) / 8) * 8-1:0] s_axis_tdata_i,   // [WIDTH-1:0] value
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [7:0]                       m_axis_tdata_o,   // [6:0] ch, [7] zero
  output logic                             m_axis_tlast_o    // last
);

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [6:0] ch;

  sitda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sitda_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (s_axis_tdata_i[WIDTH-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_ch_o    (ch),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, ch};

`ifndef SYNTHESIS
  // Every character is a minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (ch == CharMinus) || ((ch >= CharZero) && (ch <= CharNine)))
    else $error("character out of range");

  // A minus sign never ends the text.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (ch == CharMinus)) |-> !m_axis_tlast_o)
    else $error("minus sign flagged as last");

  // A character is never written over one that is still held.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("output register overwritten");

  // After a value is taken the input stays closed while it converts.
  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !s_axis_tready_o)
    else $error("input reopened during conversion");
`endif

endmodule

// ===== rtl/sitda_ctrl.sv =====
// Controller state machine of the decimal ASCII converter.
// Sequences load, conversion, leading zero removal and character output.
// Depends on sitda_pkg.
module sitda_ctrl import sitda_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StSkip = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.conv = 1'b1;
        if (sts_i.conv_last) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (sts_i.top_zero && !sts_i.dig_last) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!sts_i.sign_pend && sts_i.dig_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/sitda_dp.sv =====
// Datapath of the decimal ASCII converter: magnitude shifter, BCD register
// built by shift-add-3, digit counter and the output register.
// Depends on sitda_pkg.
module sitda_dp import sitda_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] value_i,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [6:0]       out_ch_o,
  output logic             out_last_o
);

  // Enough decimal digits for any WIDTH-bit magnitude.
  localparam int unsigned NDig  = (WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BcdW  = NDig * 4;
  localparam int unsigned BitW  = $clog2(WIDTH + 1);
  localparam int unsigned DigW  = $clog2(NDig + 1);

  logic [WIDTH-1:0] mag_q, mag_d;
  logic [BcdW-1:0]  bcd_q, bcd_d, bcd_adj;
  logic [BitW-1:0]  bit_cnt_q, bit_cnt_d;
  logic [DigW-1:0]  dig_cnt_q, dig_cnt_d;
  logic             sign_pend_q, sign_pend_d;
  logic             out_valid_q, out_valid_d;
  logic [6:0]       ch_q, ch_d;
  logic             last_q, last_d;
  logic             neg;
  logic [3:0]       top_dig;

  assign neg     = value_i[WIDTH-1];
  assign top_dig = bcd_q[BcdW-1 -: 4];

  // Add 3 to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < NDig; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                    : bcd_q[i*4 +: 4];
    end
  end

  // Next values of the working registers.
  always_comb begin
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    sign_pend_d = sign_pend_q;
    ch_d        = ch_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    priority if (cmd_i.load) begin
      mag_d       = neg ? (~value_i + WIDTH'(1)) : value_i;
      bcd_d       = '0;
      bit_cnt_d   = BitW'(WIDTH);
      dig_cnt_d   = DigW'(NDig);
      sign_pend_d = neg;
    end else if (cmd_i.conv) begin
      bcd_d     = {bcd_adj[BcdW-2:0], mag_q[WIDTH-1]};
      mag_d     = {mag_q[WIDTH-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q - BitW'(1);
    end else if (cmd_i.skip) begin
      bcd_d     = {bcd_q[BcdW-5:0], 4'd0};
      dig_cnt_d = dig_cnt_q - DigW'(1);
    end else if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      if (sign_pend_q) begin
        ch_d        = CharMinus;
        last_d      = 1'b0;
        sign_pend_d = 1'b0;
      end else begin
        ch_d      = CharZero + {3'd0, top_dig};
        last_d    = (dig_cnt_q == DigW'(1));
        bcd_d     = {bcd_q[BcdW-5:0], 4'd0};
        dig_cnt_d = dig_cnt_q - DigW'(1);
      end
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      sign_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      sign_pend_q <= sign_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    ch_q   <= ch_d;
    last_q <= last_d;
  end

  assign sts_o.conv_last = (bit_cnt_q == BitW'(1));
  assign sts_o.top_zero  = (top_dig == 4'd0);
  assign sts_o.dig_last  = (dig_cnt_q == DigW'(1));
  assign sts_o.sign_pend = sign_pend_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_ch_o    = ch_q;
  assign out_last_o  = last_q;

endmodule
